### hw/rtl/pce_pkg.sv
// Package for the polynomial coefficient engine.
// Holds the coefficient format, the operation codes and the status codes.
// No dependencies.
package pce_pkg;

    localparam int COEF_W    = 32;
    localparam int FRAC_BITS = 16;

    localparam logic [2:0] OP_ACC  = 3'd0;
    localparam logic [2:0] OP_SET  = 3'd1;
    localparam logic [2:0] OP_EVAL = 3'd2;
    localparam logic [2:0] OP_DIFF = 3'd3;
    localparam logic [2:0] OP_INT  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_LOST  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef logic signed [COEF_W-1:0] coef_t;

endpackage

### hw/rtl/pce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/pce_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on pce_pkg.
module pce_div
    import pce_pkg::*;
#(
    parameter int DW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  coef_t         dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output coef_t         quotient
);

    localparam int CW = $clog2(COEF_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [COEF_W-1:0] num_reg, num_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     den_reg, den_next;
    logic              neg_reg, neg_next;
    coef_t             q_reg, q_next;

    logic [DW:0] rem_sh;
    logic        ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_sh    = {rem_reg, num_reg[COEF_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
            neg_next  = dividend[COEF_W-1];
            num_next  = dividend[COEF_W-1] ? COEF_W'(-dividend) : dividend;
        end
        else if (busy_reg)
        begin
            // restore step: shift in one dividend bit, subtract when it fits
            rem_next = ge ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
            num_next = {num_reg[COEF_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(COEF_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_next    = neg_reg ? -coef_t'(num_next) : coef_t'(num_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### hw/rtl/polynomial_coefficient_engine.sv
// Polynomial coefficient engine: a store of MAX_DEGREE+1 signed Q16.16
// coefficients in one RAM, cleared at reset by per-entry valid bits (no
// clearing pass). Items are taken one at a time: evaluate does one
// registered multiply and one round/add per Horner step, the add using a
// coefficient read from the RAM; differentiate passes one coefficient per
// cycle through the small multiplier; integrate divides each coefficient in
// the radix-2 divider, one 32-bit division per coefficient. Each item ends
// by handing its result to the output register; the next item is accepted
// while that result waits.
// Depends on pce_pkg, pce_ram and pce_div.
module polynomial_coefficient_engine
    import pce_pkg::*;
#(
    parameter int MAX_DEGREE = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [3:0]  exponent,
    input  coef_t       coefficient,
    input  coef_t       point,
    output logic        out_valid,
    input  logic        out_stall,
    output coef_t       value,
    output logic [1:0]  status
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = COEF_W + AW + 1;
    localparam int MW    = 2 * COEF_W;
    localparam logic signed [MW-1:0] ROUND_HALF = MW'(1) << (FRAC_BITS - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ACC_RD  = 4'd1;
    localparam logic [3:0] S_EV_LOAD = 4'd2;
    localparam logic [3:0] S_EV_MUL  = 4'd3;
    localparam logic [3:0] S_EV_ADD  = 4'd4;
    localparam logic [3:0] S_DF_WR   = 4'd5;
    localparam logic [3:0] S_DF_TOP  = 4'd6;
    localparam logic [3:0] S_IN_TOP  = 4'd7;
    localparam logic [3:0] S_IN_LOAD = 4'd8;
    localparam logic [3:0] S_IN_DIV  = 4'd9;
    localparam logic [3:0] S_IN_ZERO = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    // Saturating add; the top bit of the result flags saturation.
    function automatic logic [COEF_W:0] sat_add(input coef_t a, input coef_t b);
        logic signed [COEF_W:0] s;
        s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
        if (s[COEF_W] != s[COEF_W-1])
        begin
            sat_add = {1'b1, s[COEF_W], {(COEF_W-1){~s[COEF_W]}}};
        end
        else
        begin
            sat_add = {1'b0, s[COEF_W-1:0]};
        end
    endfunction

    // Round half up, drop the fraction bits, saturate to the coefficient range.
    function automatic logic [COEF_W:0] sat_round(input logic signed [MW-1:0] p);
        logic signed [MW-1:0] t;
        t = (p + ROUND_HALF) >>> FRAC_BITS;
        if ((&t[MW-1:COEF_W-1]) || !(|t[MW-1:COEF_W-1]))
        begin
            sat_round = {1'b0, t[COEF_W-1:0]};
        end
        else
        begin
            sat_round = {1'b1, t[MW-1], {(COEF_W-1){~t[MW-1]}}};
        end
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [AW-1:0]        exp_reg, exp_next;
    coef_t                coef_reg, coef_next;
    coef_t                x_reg, x_next;
    coef_t                acc_reg, acc_next;
    logic signed [MW-1:0] prod_reg, prod_next;
    logic [AW-1:0]        k_reg, k_next;
    logic                 sat_reg, sat_next;
    logic [1:0]           status_reg, status_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic [DEPTH-1:0]     valid_reg, valid_next;
    logic                 out_valid_reg, out_valid_next;
    coef_t                out_value_reg, out_value_next;
    logic [1:0]           out_status_reg, out_status_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    coef_t                ram_wdata;
    logic [AW-1:0]        ram_raddr;
    coef_t                ram_rdata;
    coef_t                rdm;

    logic                 div_start;
    logic                 div_done;
    coef_t                div_q;

    logic signed [PW-1:0] dprod;
    logic [COEF_W:0]      add_res;
    logic [COEF_W:0]      rnd_res;
    logic [COEF_W:0]      ev_res;
    logic                 exp_ok;
    logic                 accept;

    pce_ram #(
        .WIDTH (COEF_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pce_div #(
        .DW (AW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rdm),
        .divisor  (k_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // An entry never written since reset reads as zero.
    assign rdm     = rd_ok_reg ? ram_rdata : '0;
    assign accept  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign exp_ok  = (7'(exponent) <= 7'(MAX_DEGREE));

    assign add_res = sat_add(rdm, coef_reg);
    assign rnd_res = sat_round(prod_reg);
    assign ev_res  = sat_add(coef_t'(rnd_res[COEF_W-1:0]), rdm);
    assign dprod   = $signed(rdm) * $signed({1'b0, k_reg});

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        exp_next        = exp_reg;
        coef_next       = coef_reg;
        x_next          = x_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        k_next          = k_reg;
        sat_next        = sat_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        div_start       = 1'b0;

        // drop the held result once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op;
                    exp_next    = AW'(exponent);
                    coef_next   = coefficient;
                    x_next      = point;
                    acc_next    = '0;
                    sat_next    = 1'b0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (op)
                        OP_ACC:
                        begin
                            if (!exp_ok)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ram_raddr  = AW'(exponent);
                                state_next = S_ACC_RD;
                            end
                        end
                        OP_SET:
                        begin
                            if (!exp_ok)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(exponent);
                                ram_wdata = coefficient;
                            end
                        end
                        OP_EVAL:
                        begin
                            ram_raddr  = AW'(MAX_DEGREE);
                            state_next = S_EV_LOAD;
                        end
                        OP_DIFF:
                        begin
                            ram_raddr  = AW'(1);
                            k_next     = AW'(1);
                            state_next = S_DF_WR;
                        end
                        OP_INT:
                        begin
                            ram_raddr  = AW'(MAX_DEGREE);
                            k_next     = AW'(MAX_DEGREE);
                            state_next = S_IN_TOP;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ACC_RD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = exp_reg;
                ram_wdata  = add_res[COEF_W-1:0];
                sat_next   = add_res[COEF_W];
                state_next = S_DONE;
            end
            S_EV_LOAD:
            begin
                acc_next   = rdm;
                k_next     = AW'(MAX_DEGREE - 1);
                state_next = S_EV_MUL;
            end
            S_EV_MUL:
            begin
                // hold the product in a register before rounding
                prod_next  = $signed(acc_reg) * $signed(x_reg);
                ram_raddr  = k_reg;
                state_next = S_EV_ADD;
            end
            S_EV_ADD:
            begin
                acc_next = ev_res[COEF_W-1:0];
                sat_next = sat_reg | rnd_res[COEF_W] | ev_res[COEF_W];
                if (k_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_EV_MUL;
                end
            end
            S_DF_WR:
            begin
                // write k*c[k] one place down while the next entry is read
                ram_we    = 1'b1;
                ram_waddr = k_reg - 1'b1;
                if ((&dprod[PW-1:COEF_W-1]) || !(|dprod[PW-1:COEF_W-1]))
                begin
                    ram_wdata = dprod[COEF_W-1:0];
                end
                else
                begin
                    ram_wdata = {dprod[PW-1], {(COEF_W-1){~dprod[PW-1]}}};
                    sat_next  = 1'b1;
                end
                if (k_reg == AW'(MAX_DEGREE))
                begin
                    state_next = S_DF_TOP;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    ram_raddr  = k_reg + AW'(1);
                    state_next = S_DF_WR;
                end
            end
            S_DF_TOP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(MAX_DEGREE);
                ram_wdata  = '0;
                state_next = S_DONE;
            end
            S_IN_TOP:
            begin
                if (rdm != '0)
                begin
                    status_next = ST_LOST;
                end
                ram_raddr  = k_reg - 1'b1;
                state_next = S_IN_LOAD;
            end
            S_IN_LOAD:
            begin
                div_start  = 1'b1;
                state_next = S_IN_DIV;
            end
            S_IN_DIV:
            begin
                if (div_done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = k_reg;
                    ram_wdata = div_q;
                    if (k_reg == AW'(1))
                    begin
                        state_next = S_IN_ZERO;
                    end
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        ram_raddr  = k_reg - AW'(2);
                        state_next = S_IN_LOAD;
                    end
                end
            end
            S_IN_ZERO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // advance only when the output register is free or its result is taken
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = acc_reg;
                    out_status_next = (status_reg != ST_OK) ? status_reg :
                                      (sat_reg ? ST_SAT : ST_OK);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
        rd_ok_next = valid_reg[ram_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            rd_ok_reg     <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        exp_reg        <= exp_next;
        coef_reg       <= coef_next;
        x_reg          <= x_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        k_reg          <= k_next;
        sat_reg        <= sat_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign status    = out_status_reg;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item did not start");

    a_eval_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV_MUL || state_reg == S_EV_ADD || state_reg == S_EV_LOAD)
            |-> !ram_we)
        else $error("store written during evaluate");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_IN_DIV)
        else $error("divider finished outside integrate wait");

    a_nonzero_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && op_reg != OP_EVAL) |-> acc_reg == '0)
        else $error("nonzero value for non-evaluate item");
`endif

endmodule
